// File: rtl/txc_pkg.sv
// Package for the text console writer: transaction payload types,
// operation codes and cell constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package txc_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  ATTR_RESET   = 8'h0f;
    localparam logic [15:0] BLANK_CELL   = 16'h0f20;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_cell;
        logic        scrolled;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/txc_stream_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface txc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/txc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module txc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/text_console_writer_scroll.sv
// Text console writer: ROWS x COLS cell store in one RAM, cursor, scroll.
// Put: writes the cell at the cursor; a scroll adds a row copy sweep through the RAM.
// Clear: a blanking sweep of the whole store; read and unused codes go straight to the response.
// One transaction in flight; the output register frees the input side.
// Reset: a blanking pass of the RAM, input held off.
// Depends on txc_pkg, txc_stream_if, txc_ram.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_scroll #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    txc_stream_if.sink   req,
    txc_stream_if.source rsp,
    txc_stream_if.sink   cfg
);

    localparam int CELLS     = ROWS * COLS;
    localparam int LAST_BASE = (ROWS - 1) * COLS;
    localparam int MAW       = $clog2(CELLS);
    localparam int CURW      = $clog2(CELLS + 1);
    localparam int CW        = $clog2(COLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [1:0]      after_reg, after_next;
    logic            copy_reg, copy_next;
    logic [CURW-1:0] ptr_reg, ptr_next;
    logic [CURW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0]   col_reg, col_next;
    logic            scrolled_reg, scrolled_next;
    logic            rd_hit_reg, rd_hit_next;
    logic [7:0]      attr_reg, attr_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      char_reg, char_next;
    txc_pkg::out_item_t out_reg, out_next;

    logic            ram_we;
    logic [MAW-1:0]  ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [MAW-1:0]  ram_raddr;
    logic [15:0]     ram_rdata;

    logic            accept;
    logic [CURW-1:0] ptr_m1;
    logic            is_newline;

    txc_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign accept     = req.valid && req.ready;
    assign ptr_m1     = ptr_reg - CURW'(1);
    assign is_newline = (char_reg == txc_pkg::NEWLINE_CODE);

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        copy_next      = copy_reg;
        ptr_next       = ptr_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        scrolled_next  = scrolled_reg;
        rd_hit_next    = rd_hit_reg;
        attr_next      = attr_reg;
        char_next      = char_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = txc_pkg::BLANK_CELL;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (cfg.valid && cfg.ready)
        begin
            attr_next = cfg.data;
        end

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scrolled_next = 1'b0;
                    rd_hit_next   = 1'b0;
                    char_next     = req.data.char_code;
                    ptr_next      = '0;
                    unique case (req.data.func)
                        txc_pkg::FUNC_PUT:
                        begin
                            if (cursor_reg == CURW'(CELLS))
                            begin
                                cursor_next   = CURW'(LAST_BASE);
                                col_next      = '0;
                                scrolled_next = 1'b1;
                                copy_next     = 1'b1;
                                after_next    = ST_WRITE;
                                state_next    = ST_SWEEP;
                            end
                            else
                            begin
                                state_next = ST_WRITE;
                            end
                        end
                        txc_pkg::FUNC_CLEAR:
                        begin
                            cursor_next = '0;
                            col_next    = '0;
                            copy_next   = 1'b0;
                            after_next  = ST_RESP;
                            state_next  = ST_SWEEP;
                        end
                        txc_pkg::FUNC_READ:
                        begin
                            if (32'(req.data.cell_index) < 32'(CELLS))
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = MAW'(req.data.cell_index);
                                rd_hit_next = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                // read one row ahead, write the cell behind the pointer
                if (copy_reg && (ptr_reg < CURW'(LAST_BASE)))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = MAW'(ptr_reg + CURW'(COLS));
                end
                if (ptr_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = MAW'(ptr_m1);
                    if (copy_reg && (ptr_m1 < CURW'(LAST_BASE)))
                    begin
                        ram_wdata = ram_rdata;
                    end
                end
                if (ptr_reg == CURW'(CELLS))
                begin
                    ptr_next   = '0;
                    state_next = after_reg;
                end
                else
                begin
                    ptr_next = ptr_reg + CURW'(1);
                end
            end
            ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = MAW'(cursor_reg);
                ram_wdata = {attr_reg, is_newline ? txc_pkg::SPACE_CODE : char_reg};
                ptr_next  = '0;
                if (is_newline)
                begin
                    col_next = '0;
                    if (cursor_reg >= CURW'(LAST_BASE))
                    begin
                        cursor_next   = CURW'(LAST_BASE);
                        scrolled_next = 1'b1;
                        copy_next     = 1'b1;
                        after_next    = ST_RESP;
                        state_next    = ST_SWEEP;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - CURW'(col_reg) + CURW'(COLS);
                        state_next  = ST_RESP;
                    end
                end
                else
                begin
                    cursor_next = cursor_reg + CURW'(1);
                    col_next    = (col_reg == CW'(COLS - 1)) ? '0 : col_reg + CW'(1);
                    state_next  = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.cursor_cell = 11'(cursor_reg);
                    out_next.scrolled    = scrolled_reg;
                    out_next.read_char   = rd_hit_reg ? ram_rdata[7:0] : 8'd0;
                    out_next.read_attr   = rd_hit_reg ? ram_rdata[15:8] : 8'd0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            after_reg     <= ST_IDLE;
            copy_reg      <= 1'b0;
            ptr_reg       <= '0;
            cursor_reg    <= '0;
            col_reg       <= '0;
            scrolled_reg  <= 1'b0;
            rd_hit_reg    <= 1'b0;
            attr_reg      <= txc_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            copy_reg      <= copy_next;
            ptr_reg       <= ptr_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            scrolled_reg  <= scrolled_next;
            rd_hit_reg    <= rd_hit_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CURW'(CELLS))
        else $error("cursor beyond end of store");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < CW'(COLS))
        else $error("column out of range");

    a_past_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg == CURW'(CELLS)) |-> (col_reg == '0))
        else $error("cursor past end with nonzero column");

    a_sweep_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |=> !(req.valid && req.ready) || (state_reg == ST_IDLE))
        else $error("transaction taken during sweep");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
        else $error("cell write out of range");
`endif

endmodule

`default_nettype wire

// File: test/text_console_checker.sv
// Checker for the text console writer: keeps its own copy of the screen, cursor and
// attribute, predicts each response and compares it field by field.
// Depends on txc_pkg.
`timescale 1ns / 1ps

module text_console_checker #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  txc_pkg::in_item_t  req_data,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  txc_pkg::out_item_t rsp_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int CELLS = ROWS * COLS;

    logic [15:0]        screen [CELLS];
    int unsigned        cursor;
    logic [7:0]         attr;
    txc_pkg::out_item_t expected_reports [$];
    int                 errors;

    task automatic blank_screen();
        int i;
        for (i = 0; i < CELLS; i++)
            screen[i] = txc_pkg::BLANK_CELL;
    endtask

    task automatic shift_rows_up();
        int i;
        for (i = 0; i < CELLS - COLS; i++)
            screen[i] = screen[i + COLS];
        for (i = CELLS - COLS; i < CELLS; i++)
            screen[i] = txc_pkg::BLANK_CELL;
    endtask

    task automatic apply_console_op(input txc_pkg::in_item_t op,
                                    output txc_pkg::out_item_t report);
        int unsigned row;
        logic [7:0]  glyph;
        report = '0;
        case (op.func)
            txc_pkg::FUNC_PUT:
            begin
                if (cursor >= CELLS)
                begin
                    shift_rows_up();
                    cursor -= COLS;
                    report.scrolled = 1'b1;
                end
                glyph = (op.char_code == txc_pkg::NEWLINE_CODE) ? txc_pkg::SPACE_CODE
                                                                : op.char_code;
                screen[cursor] = {attr, glyph};
                row = cursor / COLS;
                if (op.char_code == txc_pkg::NEWLINE_CODE)
                begin
                    if (row == ROWS - 1)
                    begin
                        shift_rows_up();
                        report.scrolled = 1'b1;
                        cursor = (ROWS - 1) * COLS;
                    end
                    else
                    begin
                        cursor = (row + 1) * COLS;
                    end
                end
                else
                begin
                    cursor += 1;
                end
            end
            txc_pkg::FUNC_CLEAR:
            begin
                blank_screen();
                cursor = 0;
            end
            txc_pkg::FUNC_READ:
            begin
                if (op.cell_index < CELLS)
                begin
                    report.read_char = screen[op.cell_index][7:0];
                    report.read_attr = screen[op.cell_index][15:8];
                end
            end
            default:
            begin
            end
        endcase
        report.cursor_cell = 11'(cursor);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        txc_pkg::out_item_t want;
        if (!rst_n)
        begin
            blank_screen();
            cursor = 0;
            attr = txc_pkg::ATTR_RESET;
            expected_reports.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                attr = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display({"%0t: unexpected response: expected none, ",
                              "actual cursor %0d scrolled %0d char %0d attr %0d"},
                             $time, rsp_data.cursor_cell, rsp_data.scrolled,
                             rsp_data.read_char, rsp_data.read_attr);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("cursor_cell", int'(want.cursor_cell),
                                int'(rsp_data.cursor_cell));
                    check_field("scrolled", int'(want.scrolled), int'(rsp_data.scrolled));
                    check_field("read_char", int'(want.read_char), int'(rsp_data.read_char));
                    check_field("read_attr", int'(want.read_attr), int'(rsp_data.read_attr));
                end
            end
            if (req_valid && req_ready)
            begin
                apply_console_op(req_data, want);
                expected_reports.push_back(want);
            end
            fail_count <= errors;
            pending <= expected_reports.size();
        end
    end

endmodule

// File: test/tb_text_console_writer_scroll.sv
// Testbench top for the text console writer: drives put, clear, read, unused-code and
// attribute transactions with random stalls and gives the verdict.
// Depends on txc_pkg, txc_stream_if, text_console_writer_scroll, text_console_checker.
`timescale 1ns / 1ps

module tb_text_console_writer_scroll;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int CELLS = ROWS * COLS;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int OP_TARGET = 1600;
    localparam int STEADY_FIRST = 700;
    localparam int STEADY_LAST = 1000;

    logic clk;
    logic rst_n;
    logic steady;
    int   ops_sent;
    int   fail_count;
    int   pending;

    txc_stream_if #(.T(txc_pkg::in_item_t))  req_if ();
    txc_stream_if #(.T(txc_pkg::out_item_t)) rsp_if ();
    txc_stream_if #(.T(logic [7:0]))         cfg_if ();

    text_console_writer_scroll #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    text_console_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_if.valid),
        .req_ready  (req_if.ready),
        .req_data   (req_if.data),
        .rsp_valid  (rsp_if.valid),
        .rsp_ready  (rsp_if.ready),
        .rsp_data   (rsp_if.data),
        .cfg_valid  (cfg_if.valid),
        .cfg_ready  (cfg_if.ready),
        .cfg_data   (cfg_if.data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
        rsp_if.ready <= steady || ($urandom_range(0, 99) >= 24);

    function automatic txc_pkg::in_item_t op_of(logic [1:0] f, logic [7:0] c,
                                                logic [10:0] idx);
        txc_pkg::in_item_t op;
        op.func = f;
        op.char_code = c;
        op.cell_index = idx;
        return op;
    endfunction

    task automatic send_op(input txc_pkg::in_item_t op);
        steady = (ops_sent >= STEADY_FIRST) && (ops_sent < STEADY_LAST);
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 24);
        end
        req_if.valid <= 1'b1;
        req_if.data <= op;
        do @(posedge clk); while (!req_if.ready);
        if (op.func != FUNC_UNUSED)
            ops_sent++;
    endtask

    task automatic put_char(input logic [7:0] c);
        send_op(op_of(txc_pkg::FUNC_PUT, c, 11'($urandom_range(0, 2047))));
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send_op(op_of(txc_pkg::FUNC_READ, 8'($urandom_range(0, 255)), idx));
    endtask

    task automatic wipe_screen();
        send_op(op_of(txc_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047))));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_attr(input logic [7:0] value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        int          k;
        int          len;
        logic [10:0] idx;
        logic [1:0]  f;
        logic [7:0]  a;

        rst_n = 1'b0;
        steady = 1'b0;
        ops_sent = 0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'd2047);
        send_op(op_of(FUNC_UNUSED, 8'hff, 11'd2047));
        send_op(op_of(FUNC_UNUSED, 8'h00, 11'd0));
        put_char(8'h00);
        put_char(8'hff);
        put_char(txc_pkg::NEWLINE_CODE);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);
        write_attr(8'h00);
        put_char(8'h41);
        read_cell(11'(COLS));
        write_attr(8'hff);
        put_char(8'h7e);
        read_cell(11'(COLS + 1));
        wipe_screen();
        read_cell(11'(COLS));

        while (ops_sent < OP_TARGET)
        begin
            k = $urandom_range(0, 99);
            if (k < 2)
            begin
                wipe_screen();
            end
            else if (k < 4)
            begin
                // fill to the end of the last row, then newline with the scroll pending
                wipe_screen();
                repeat (ROWS - 1) put_char(txc_pkg::NEWLINE_CODE);
                repeat (COLS) put_char(8'($urandom_range(8'h21, 8'h7e)));
                put_char(txc_pkg::NEWLINE_CODE);
                read_cell(11'(CELLS - COLS - 1));
                read_cell(11'(CELLS - COLS));
            end
            else if (k < 9)
            begin
                case ($urandom_range(0, 3))
                    0: a = 8'h00;
                    1: a = 8'hff;
                    default: a = 8'($urandom_range(0, 255));
                endcase
                write_attr(a);
            end
            else if (k < 19)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    f = 2'($urandom_range(0, 3));
                    if (f == txc_pkg::FUNC_CLEAR && $urandom_range(0, 9) != 0)
                        f = txc_pkg::FUNC_READ;
                    send_op(op_of(f, 8'($urandom_range(0, 255)),
                                  11'($urandom_range(0, 2047))));
                end
            end
            else if (k < 35)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    k = $urandom_range(0, 9);
                    if (k < 7)
                        idx = 11'($urandom_range(0, CELLS - 1));
                    else if (k < 9)
                        idx = 11'($urandom_range(CELLS - COLS, CELLS - 1));
                    else
                        idx = 11'($urandom_range(0, 2047));
                    read_cell(idx);
                end
            end
            else
            begin
                k = $urandom_range(0, 99);
                if (k < 60)
                    len = $urandom_range(0, 15);
                else if (k < 75)
                    len = COLS;
                else if (k < 88)
                    len = $urandom_range(16, COLS - 1);
                else
                    len = $urandom_range(COLS + 1, 2 * COLS);
                repeat (len) put_char(8'($urandom_range(0, 255)));
                put_char(txc_pkg::NEWLINE_CODE);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
